/* design/lgs_pkg.sv */
package lgs_pkg;

  localparam int GRID_DIM   = 64;
  localparam int MIN_DIM    = 10;
  localparam int COORD_W    = $clog2(GRID_DIM);
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int GEN_W      = 32;
  localparam int CMD_W      = 2;
  localparam int STEP_W     = $clog2(GRID_DIM + 1);
  localparam int NBR_W      = 4;

  localparam logic [NBR_W-1:0] BIRTH_CNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_CNT = NBR_W'(2);

  localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  typedef logic [GRID_DIM-1:0] row_t;

  typedef struct packed {
    logic               clear;
    logic               shift;
    logic               flip;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } cell_ctl_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v < CFG_W'(MIN_DIM)) r = CFG_W'(MIN_DIM);
    else if (v > CFG_W'(GRID_DIM)) r = CFG_W'(GRID_DIM);
    else r = v;
    return r;
  endfunction

endpackage

/* design/lgs_cmd_if.sv */
interface lgs_cmd_if;
  import lgs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [COORD_W-1:0]       cell_x;
  logic [COORD_W-1:0]       cell_y;

  modport source (output valid, output cmd, output cell_x, output cell_y, input ready);
  modport sink   (input valid, input cmd, input cell_x, input cell_y, output ready);
endinterface

/* design/lgs_res_if.sv */
interface lgs_res_if;
  import lgs_pkg::*;

  logic             valid;
  logic             ready;
  logic             cell_alive;
  logic [GEN_W-1:0] generation_count;

  modport source (output valid, output cell_alive, output generation_count, input ready);
  modport sink   (input valid, input cell_alive, input generation_count, output ready);
endinterface

/* design/lgs_cfg_if.sv */
interface lgs_cfg_if;
  import lgs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/lgs_life_lane.sv */
module lgs_life_lane (
  input  logic [2:0] above,
  input  logic [2:0] center,
  input  logic [2:0] below,
  output logic       alive_nxt
);
  import lgs_pkg::*;

  logic [NBR_W-1:0] cnt;

  always_comb begin
    cnt = NBR_W'(above[0]) + NBR_W'(above[1]) + NBR_W'(above[2])
        + NBR_W'(center[0]) + NBR_W'(center[2])
        + NBR_W'(below[0]) + NBR_W'(below[1]) + NBR_W'(below[2]);
    alive_nxt = (cnt == BIRTH_CNT) || (center[1] && (cnt == SURVIVE_CNT));
  end
endmodule

/* design/lgs_row_cell.sv */
module lgs_row_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lgs_pkg::cell_ctl_t         ctl,
  input  logic [lgs_pkg::COORD_W-1:0] idx,
  input  lgs_pkg::row_t              shift_in,
  output lgs_pkg::row_t              row_q,
  output logic                       hit
);
  import lgs_pkg::*;

  row_t row_r;
  row_t row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ctl.clear) begin
      row_nxt = '0;
    end else if (ctl.shift) begin
      row_nxt = shift_in;
    end else if (ctl.flip && (ctl.row == idx)) begin
      row_nxt[ctl.col] = ~row_r[ctl.col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;
  assign hit   = (ctl.row == idx) && row_r[ctl.col];
endmodule

/* design/life_grid_generation_step_unit.sv */
// Toggle, clear, query: the beat moves to the result state, which loads the output register once it
// is free; the next input beat is taken when the block is back in idle. Step: a sweep of the 64-row
// cell ring through the three-row window (one row per cycle, plus a fill step), then the result
// state loads the output register.
// A result waiting in the output register does not hold off the next input beat; the new result
// then holds until the output register is free. Synchronous active-low reset: all cells dead,
// counter zero, width and height 64.
module life_grid_generation_step_unit (
  input  logic          clk,
  input  logic          rst_n,
  lgs_cmd_if.sink       in_if,
  lgs_res_if.source     out_if,
  lgs_cfg_if.sink       cfg_if
);
  import lgs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [STEP_W-1:0]  step_cnt_r, step_cnt_nxt;
  logic [GEN_W-1:0]   gen_cnt_r, gen_cnt_nxt;
  logic [COORD_W-1:0] x_r, y_r;
  logic [CFG_W-1:0]   width_r, height_r;
  row_t               prev_r, cur_r, prev_nxt, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_alive_r;
  logic [GEN_W-1:0]   out_gen_r;

  logic               in_acc;
  logic               out_free;
  logic [CFG_W-1:0]   w_eff, h_eff;
  row_t               col_mask;
  row_t               head_masked;
  row_t               new_row;
  row_t               tail_row;
  row_t               lane_out;
  cell_ctl_t          ctl;
  row_t               rows [GRID_DIM];
  logic [GRID_DIM-1:0] hit_vec;
  logic [GRID_DIM+1:0] pad_prev, pad_cur, pad_next;
  logic               last_step;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;

  assign w_eff = clamp_dim(width_r);
  assign h_eff = clamp_dim(height_r);

  always_comb begin
    for (int c = 0; c < GRID_DIM; c++) begin
      col_mask[c] = (CFG_W'(c) < w_eff);
    end
  end

  assign last_step   = (step_cnt_r == STEP_W'(GRID_DIM));
  assign head_masked = (CFG_W'(step_cnt_r) < h_eff) ? (rows[0] & col_mask) : '0;

  assign pad_prev = {1'b0, prev_r, 1'b0};
  assign pad_cur  = {1'b0, cur_r, 1'b0};
  assign pad_next = {1'b0, head_masked, 1'b0};

  for (genvar c = 0; c < GRID_DIM; c++) begin : g_lane
    lgs_life_lane u_lane (
      .above     (pad_prev[c+2:c]),
      .center    (pad_cur[c+2:c]),
      .below     (pad_next[c+2:c]),
      .alive_nxt (lane_out[c])
    );
  end

  assign new_row = ((step_cnt_r != '0) && (CFG_W'(step_cnt_r) <= h_eff))
                   ? (lane_out & col_mask) : '0;

  always_comb begin
    ctl.clear = in_acc && (in_if.cmd == CMD_CLEAR);
    ctl.shift = (state_r == ST_STEP);
    ctl.flip  = in_acc && (in_if.cmd == CMD_TOGGLE)
                && (CFG_W'(in_if.cell_x) < w_eff) && (CFG_W'(in_if.cell_y) < h_eff);
    ctl.col   = (state_r == ST_IDLE) ? in_if.cell_x : x_r;
    ctl.row   = (state_r == ST_IDLE) ? in_if.cell_y : y_r;
  end

  for (genvar g = 0; g < GRID_DIM; g++) begin : g_row
    if (g == GRID_DIM - 1) begin : g_tail
      assign tail_row = new_row;
      lgs_row_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .idx      (COORD_W'(g)),
        .shift_in (tail_row),
        .row_q    (rows[g]),
        .hit      (hit_vec[g])
      );
    end else begin : g_body
      lgs_row_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .idx      (COORD_W'(g)),
        .shift_in (rows[g+1]),
        .row_q    (rows[g]),
        .hit      (hit_vec[g])
      );
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_cnt_nxt  = step_cnt_r;
    gen_cnt_nxt   = gen_cnt_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_if.ready ? 1'b0 : out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.cmd == CMD_STEP) begin
            state_nxt    = ST_STEP;
            step_cnt_nxt = '0;
            cur_nxt      = '0;
          end else begin
            state_nxt = ST_EVAL;
            if (in_if.cmd == CMD_CLEAR) begin
              gen_cnt_nxt = '0;
            end
          end
        end
      end
      ST_STEP: begin
        prev_nxt     = cur_r;
        cur_nxt      = head_masked;
        step_cnt_nxt = step_cnt_r + STEP_W'(1);
        if (last_step) begin
          state_nxt   = ST_EVAL;
          gen_cnt_nxt = gen_cnt_r + GEN_W'(1);
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_cnt_r  <= '0;
      gen_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      width_r     <= CFG_W'(GRID_DIM);
      height_r    <= CFG_W'(GRID_DIM);
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      gen_cnt_r   <= gen_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_WIDTH) width_r <= cfg_if.data;
        if (cfg_if.index == REG_HEIGHT) height_r <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    if (in_acc) begin
      x_r <= in_if.cell_x;
      y_r <= in_if.cell_y;
    end
    if ((state_r == ST_EVAL) && out_free) begin
      out_alive_r <= |hit_vec;
      out_gen_r   <= gen_cnt_r;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.cell_alive       = out_alive_r;
  assign out_if.generation_count = out_gen_r;

  a_step_bumps_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) && last_step |=> gen_cnt_r == $past(gen_cnt_r) + GEN_W'(1))
    else $error("generation counter did not advance at end of sweep");

  a_clear_zeroes_gen: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_if.cmd == CMD_CLEAR) |=> gen_cnt_r == '0)
    else $error("clear did not reset generation counter");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> step_cnt_r <= STEP_W'(GRID_DIM))
    else $error("sweep counter ran past the last row");

  a_sweep_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) && last_step |=> state_r == ST_EVAL)
    else $error("sweep did not hand over to result");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) && out_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not loaded into output register");
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lgs_pkg::*;

  typedef struct packed {
    logic             alive;
    logic [GEN_W-1:0] gen;
  } cell_report_t;

  logic clk;
  logic rst_n;

  lgs_cmd_if cmd_bus();
  lgs_res_if res_bus();
  lgs_cfg_if cfg_bus();

  life_grid_generation_step_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_bus),
    .out_if (res_bus),
    .cfg_if (cfg_bus)
  );

  // board copy kept in step with the block
  row_t             board [GRID_DIM];
  logic [GEN_W-1:0] gen_count;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  cell_report_t cell_report_q [$];
  int           fail_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           recv_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic int used_dim(input logic [CFG_W-1:0] v);
    int r;
    r = int'(v);
    if (r < MIN_DIM) r = MIN_DIM;
    if (r > GRID_DIM) r = GRID_DIM;
    return r;
  endfunction

  function automatic void board_advance();
    row_t nxt [GRID_DIM];
    int   w;
    int   h;
    int   cnt;
    int   nx;
    int   ny;
    w = used_dim(width_reg);
    h = used_dim(height_reg);
    for (int y = 0; y < GRID_DIM; y++) nxt[y] = '0;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        cnt = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            nx = x + dx;
            ny = y + dy;
            if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h)
              cnt += int'(board[ny][nx]);
          end
        end
        if (cnt == 3 || (board[y][x] && cnt == 2)) nxt[y][x] = 1'b1;
      end
    end
    for (int y = 0; y < GRID_DIM; y++) board[y] = nxt[y];
    gen_count = gen_count + 1'b1;
  endfunction

  function automatic cell_report_t board_apply(input logic [CMD_W-1:0] c,
                                               input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
    cell_report_t r;
    case (c)
      CMD_TOGGLE: begin
        if (int'(x) < used_dim(width_reg) && int'(y) < used_dim(height_reg))
          board[y][x] = ~board[y][x];
      end
      CMD_STEP: begin
        board_advance();
      end
      CMD_CLEAR: begin
        for (int i = 0; i < GRID_DIM; i++) board[i] = '0;
        gen_count = '0;
      end
      default: begin
      end
    endcase
    r.alive = board[y][x];
    r.gen   = gen_count;
    return r;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid  <= 1'b1;
    cmd_bus.cmd    <= c;
    cmd_bus.cell_x <= x;
    cmd_bus.cell_y <= y;
    do @(posedge clk); while (!cmd_bus.ready);
    cell_report_q.push_back(board_apply(c, x, y));
  endtask

  task automatic wait_drain();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (cell_report_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_WIDTH) width_reg = data;
    else height_reg = data;
  endtask

  task automatic set_area(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (recv_hold_cycles > 0) begin
      res_bus.ready <= 1'b0;
      recv_hold_cycles = recv_hold_cycles - 1;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cell_report_t exp_r;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (cell_report_q.size() == 0) begin
        $display("%0t: unexpected beat alive=%0d gen=%0d", $realtime,
                 res_bus.cell_alive, res_bus.generation_count);
        fail_count++;
      end else begin
        exp_r = cell_report_q.pop_front();
        if (res_bus.cell_alive !== exp_r.alive) begin
          $display("%0t: cell_alive expected %0d actual %0d", $realtime,
                   exp_r.alive, res_bus.cell_alive);
          fail_count++;
        end
        if (res_bus.generation_count !== exp_r.gen) begin
          $display("%0t: generation_count expected %0d actual %0d", $realtime,
                   exp_r.gen, res_bus.generation_count);
          fail_count++;
        end
      end
    end
  end

  task automatic test_basic_ops();
    send_cmd(CMD_QUERY, 6'd0, 6'd0);
    send_cmd(CMD_QUERY, 6'd63, 6'd63);
    send_cmd(CMD_TOGGLE, 6'd0, 6'd0);
    send_cmd(CMD_TOGGLE, 6'd63, 6'd63);
    send_cmd(CMD_TOGGLE, 6'd0, 6'd63);
    send_cmd(CMD_STEP, 6'd0, 6'd0);
    // vertical blinker
    send_cmd(CMD_TOGGLE, 6'd5, 6'd4);
    send_cmd(CMD_TOGGLE, 6'd5, 6'd5);
    send_cmd(CMD_TOGGLE, 6'd5, 6'd6);
    send_cmd(CMD_STEP, 6'd4, 6'd5);
    send_cmd(CMD_QUERY, 6'd5, 6'd4);
    send_cmd(CMD_STEP, 6'd5, 6'd4);
    send_cmd(CMD_CLEAR, 6'd5, 6'd5);
    send_cmd(CMD_QUERY, 6'd5, 6'd5);
    wait_drain();
  endtask

  task automatic test_area_limits();
    send_cmd(CMD_TOGGLE, 6'd40, 6'd40);
    set_area(7'd10, 7'd10);
    send_cmd(CMD_QUERY, 6'd40, 6'd40);
    send_cmd(CMD_TOGGLE, 6'd20, 6'd20);
    // corner triple grows into a block at the area edge
    send_cmd(CMD_TOGGLE, 6'd9, 6'd9);
    send_cmd(CMD_TOGGLE, 6'd8, 6'd9);
    send_cmd(CMD_TOGGLE, 6'd9, 6'd8);
    send_cmd(CMD_STEP, 6'd8, 6'd8);
    send_cmd(CMD_QUERY, 6'd40, 6'd40);
    send_cmd(CMD_TOGGLE, 6'd10, 6'd3);
    wait_drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      send_cmd((i == 20) ? CMD_STEP : (i[0] ? CMD_QUERY : CMD_TOGGLE),
               6'($urandom_range(9)), 6'($urandom_range(9)));
    end
    wait_drain();
    for (int i = 0; i < 10; i++) send_cmd(CMD_QUERY, 6'($urandom_range(9)), 6'($urandom_range(9)));
    wait_drain();
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int w;
    int h;
    int bw;
    int bh;
    int bx;
    int by;
    int n;
    sent = 0;
    while (sent < n_items) begin
      w = used_dim(width_reg);
      h = used_dim(height_reg);
      if ($urandom_range(99) < 80) begin
        // seed a small window, then run it a few generations
        bw = (w < 8) ? w : 8;
        bh = (h < 8) ? h : 8;
        bx = $urandom_range(w - bw);
        by = $urandom_range(h - bh);
        if ($urandom_range(2) == 0) begin
          send_cmd(CMD_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)));
          sent++;
        end
        n = $urandom_range(20, 3);
        repeat (n) begin
          send_cmd(CMD_TOGGLE, 6'(bx + $urandom_range(bw - 1)), 6'(by + $urandom_range(bh - 1)));
          sent++;
        end
        n = $urandom_range(4, 1);
        repeat (n) begin
          send_cmd(CMD_STEP, 6'(bx + $urandom_range(bw - 1)), 6'(by + $urandom_range(bh - 1)));
          sent++;
          repeat ($urandom_range(3, 1)) begin
            send_cmd(CMD_QUERY, 6'(bx + $urandom_range(bw - 1)),
                     6'(by + $urandom_range(bh - 1)));
            sent++;
          end
        end
      end else begin
        send_cmd(CMD_W'($urandom_range(3)), 6'($urandom_range(63)), 6'($urandom_range(63)));
        sent++;
      end
    end
    wait_drain();
  endtask

  task automatic test_config_sweep();
    logic [CFG_W-1:0] w_pick [9] = '{7'd0, 7'd127, 7'd10, 7'd64, 7'd12, 7'd65, 7'd9, 7'd16, 7'd63};
    logic [CFG_W-1:0] h_pick [9] = '{7'd127, 7'd0, 7'd10, 7'd64, 7'd65, 7'd11, 7'd20, 7'd9, 7'd14};
    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == 8) set_area(7'($urandom_range(127)), 7'($urandom_range(127)));
      else set_area(w_pick[p], h_pick[p]);
      test_random_traffic(78);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    fail_count       = 0;
    send_idle_pct    = 29;
    recv_idle_pct    = 67;
    recv_hold_cycles = 0;
    cmd_bus.valid    = 1'b0;
    cmd_bus.cmd      = CMD_QUERY;
    cmd_bus.cell_x   = '0;
    cmd_bus.cell_y   = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_WIDTH;
    cfg_bus.data     = '0;
    res_bus.ready    = 1'b0;
    for (int i = 0; i < GRID_DIM; i++) board[i] = '0;
    gen_count  = '0;
    width_reg  = 7'd64;
    height_reg = 7'd64;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_area_limits();
    test_backpressure();
    test_config_sweep();

    wait_drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && cell_report_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
